// File: src/ftg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftg_pkg: shared constants of the four-tap GFSR generator
// Default sizes, tap lags, request codes and output queue sizing.
// ----------------------------------------------------------------------------
package ftg_pkg;

    localparam int unsigned DEF_RING_DEPTH  = 16384;
    localparam int unsigned DEF_WORD_BITS   = 32;

    localparam int unsigned LOAD_INDEX_BITS = 14;
    localparam int unsigned LOAD_VALUE_BITS = 32;
    localparam int unsigned OUT_BITS        = 32;

    localparam int unsigned NUM_TAPS = 4;
    localparam int unsigned TAP_LAGS [NUM_TAPS] = '{471, 1586, 6988, 9689};

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_GEN  = 1'b1;

    localparam int unsigned OUT_QUEUE_DEPTH = 3;
    localparam int unsigned QPTR_BITS       = $clog2(OUT_QUEUE_DEPTH);
    localparam int unsigned QCNT_BITS       = $clog2(OUT_QUEUE_DEPTH + 1);

endpackage

// File: src/four_tap_gfsr_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_tap_gfsr_generator: four-tap XOR lagged shift-register generator
// Load beats seed the ring; generate beats return x[n-471]^x[n-1586]^
// x[n-6988]^x[n-9689] and store it at the new ring position.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while o_stall is low, loads and generates
// alike; a generated word passes the registered ring reads and the result
// queue to reach the output. The ring is held in two mirrored single-write,
// dual-read RAMs, so the four tap reads of one beat issue together; every
// beat writes the ring once, in the cycle after acceptance, and that pending
// write is forwarded to a following tap read of the same slot. A three-word
// result queue absorbs output stalls; input stall rises only when that queue
// and the word in flight would fill it. Ring slots read before being loaded
// or generated return arbitrary data; there is no clearing pass after reset.
module four_tap_gfsr_generator
    import ftg_pkg::*;
#(
    parameter int unsigned RING_DEPTH = DEF_RING_DEPTH,
    parameter int unsigned WORD_BITS  = DEF_WORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [LOAD_INDEX_BITS-1:0] i_load_index,
    input  logic [LOAD_VALUE_BITS-1:0] i_load_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [OUT_BITS-1:0]        o_random_word
);

    localparam int unsigned AW       = $clog2(RING_DEPTH);
    localparam int unsigned EXT_BITS = (WORD_BITS > OUT_BITS) ? WORD_BITS : OUT_BITS;

    logic                 r_s1_valid;
    logic                 r_s1_gen;
    logic [AW-1:0]        r_s1_addr;
    logic [WORD_BITS-1:0] r_s1_ldata;
    logic [NUM_TAPS-1:0]  r_fwd;
    logic [WORD_BITS-1:0] r_fwd_data;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        n_pos;

    logic                 w_accept;
    logic [AW-1:0]        w_next_pos;
    logic [AW-1:0]        w_raddr [NUM_TAPS];
    logic [WORD_BITS-1:0] w_rdata [NUM_TAPS];
    logic [WORD_BITS-1:0] w_tap   [NUM_TAPS];
    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_wdata;
    logic [EXT_BITS-1:0]  w_word_ext;
    logic [EXT_BITS-1:0]  w_load_ext;
    logic                 w_inflight;
    logic [QCNT_BITS-1:0] w_q_count;
    logic [QCNT_BITS:0]   w_used;

    // admit a beat only when the result queue has room for everything in flight
    assign w_inflight = r_s1_valid & r_s1_gen;
    assign w_used     = {1'b0, w_q_count} + (QCNT_BITS + 1)'(w_inflight);
    assign o_stall    = (w_used >= (QCNT_BITS + 1)'(OUT_QUEUE_DEPTH));
    assign w_accept   = i_valid & ~o_stall;

    assign w_next_pos = (r_pos == AW'(RING_DEPTH - 1)) ? '0 : r_pos + AW'(1);

    always_comb begin
        for (int t = 0; t < NUM_TAPS; t++) begin
            if (w_next_pos >= AW'(TAP_LAGS[t])) begin
                w_raddr[t] = w_next_pos - AW'(TAP_LAGS[t]);
            end else begin
                w_raddr[t] = w_next_pos + AW'(RING_DEPTH - TAP_LAGS[t]);
            end
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            n_pos = (i_req_type == REQ_GEN) ? w_next_pos : '0;
        end
    end

    // stage one: combine taps, write back
    always_comb begin
        w_word = '0;
        for (int t = 0; t < NUM_TAPS; t++) begin
            w_tap[t] = r_fwd[t] ? r_fwd_data : w_rdata[t];
            w_word   = w_word ^ w_tap[t];
        end
    end

    assign w_wdata    = r_s1_gen ? w_word : r_s1_ldata;
    assign w_word_ext = EXT_BITS'(w_word);
    assign w_load_ext = EXT_BITS'(i_load_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_gen   <= (i_req_type == REQ_GEN);
        r_s1_addr  <= (i_req_type == REQ_GEN) ? w_next_pos : AW'(i_load_index);
        r_s1_ldata <= w_load_ext[WORD_BITS-1:0];
        r_fwd_data <= w_wdata;
        for (int t = 0; t < NUM_TAPS; t++) begin
            r_fwd[t] <= r_s1_valid & (w_raddr[t] == r_s1_addr);
        end
    end

    ftg_ring_mem #(
        .DEPTH (RING_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_ring_lo (
        .i_clk     (i_clk),
        .i_wen     (r_s1_valid),
        .i_waddr   (r_s1_addr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr[0]),
        .i_raddr_b (w_raddr[1]),
        .o_rdata_a (w_rdata[0]),
        .o_rdata_b (w_rdata[1])
    );

    ftg_ring_mem #(
        .DEPTH (RING_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_ring_hi (
        .i_clk     (i_clk),
        .i_wen     (r_s1_valid),
        .i_waddr   (r_s1_addr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr[2]),
        .i_raddr_b (w_raddr[3]),
        .o_rdata_a (w_rdata[2]),
        .o_rdata_b (w_rdata[3])
    );

    ftg_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_inflight),
        .i_data  (w_word_ext[OUT_BITS-1:0]),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_random_word),
        .o_count (w_q_count)
    );

endmodule

// File: src/ftg_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftg_ring_mem: ring word store
// Synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ftg_ring_mem
    import ftg_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_RING_DEPTH,
    parameter int unsigned WIDTH = DEF_WORD_BITS,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wen,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: src/ftg_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftg_out_queue: result queue
// Small FIFO that decouples the generator pipeline from output stalls.
// ----------------------------------------------------------------------------
module ftg_out_queue
    import ftg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [OUT_BITS-1:0]  i_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [OUT_BITS-1:0]  o_data,
    output logic [QCNT_BITS-1:0] o_count
);

    logic [OUT_BITS-1:0]  r_mem [OUT_QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] n_count;
    logic                 w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid & ~i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(OUT_QUEUE_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(OUT_QUEUE_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: sim/gfsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfsr_checker: output checker for the four-tap GFSR generator
// Watches both channels of the block. Each accepted input beat updates a
// private copy of the word ring and ring position. Each generate beat queues
// the XOR of the four lagged words it should produce. Each accepted output
// beat is compared with the oldest queued word. Unexpected words and
// mismatches are counted and passed to the top level.
// ----------------------------------------------------------------------------
module gfsr_checker
    import ftg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_req_type,
    input  logic [LOAD_INDEX_BITS-1:0] i_load_index,
    input  logic [LOAD_VALUE_BITS-1:0] i_load_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [OUT_BITS-1:0]        i_random_word,
    output int                         o_fail_count,
    output int                         o_waiting
);

    localparam int unsigned DEPTH = DEF_RING_DEPTH;

    logic [OUT_BITS-1:0] ring_copy [DEPTH];
    int unsigned         ring_pos;
    logic [OUT_BITS-1:0] pending_words [$];
    int                  mismatches;

    function automatic logic [OUT_BITS-1:0] advance_ring();
        logic [OUT_BITS-1:0] word;
        int unsigned         t;
        ring_pos = (ring_pos + 1) % DEPTH;
        word = '0;
        for (t = 0; t < NUM_TAPS; t++) begin
            word ^= ring_copy[(ring_pos + DEPTH - TAP_LAGS[t]) % DEPTH];
        end
        ring_copy[ring_pos] = word;
        return word;
    endfunction

    always @(posedge i_clk) begin : track_beats
        logic [OUT_BITS-1:0] want;
        if (!i_rst_n) begin
            ring_pos = 0;
            pending_words.delete();
            mismatches = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_LOAD) begin
                    ring_copy[i_load_index % DEPTH] = i_load_value[OUT_BITS-1:0];
                    ring_pos = 0;
                end else begin
                    pending_words.push_back(advance_ring());
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected random_word %h", i_random_word);
                end else begin
                    want = pending_words.pop_front();
                    if (i_random_word !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: random_word expected %h got %h",
                                     want, i_random_word);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_waiting    <= pending_words.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the four-tap GFSR generator
// Seeds every unseeded ring slot that each run of generate beats will read,
// then issues the run, with random gaps on the input and random output
// stalls. A short directed part covers the field extremes and lag wrap;
// random runs may be cut short by a load. Long runs go past the shortest
// lag so generated words feed back into the taps. The checker predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ftg_pkg::*;

    localparam int unsigned RING           = DEF_RING_DEPTH;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int unsigned GEN_TARGET     = 1200;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_req     = REQ_LOAD;
    logic [LOAD_INDEX_BITS-1:0] in_index   = '0;
    logic [LOAD_VALUE_BITS-1:0] in_value   = '0;
    logic                       out_stall  = 1'b0;
    logic                       dut_stall;
    logic                       dut_valid;
    logic [OUT_BITS-1:0]        dut_word;
    int                         fail_count;
    int                         waiting;

    bit          seeded [RING];
    int unsigned stim_pos    = 0;
    int unsigned calm_beats  = 0;
    int unsigned gen_beats   = 0;
    int unsigned stall_left  = 0;
    int unsigned free_left   = 0;
    int          quiet_cycles = 0;

    four_tap_gfsr_generator dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (dut_stall),
        .i_req_type    (in_req),
        .i_load_index  (in_index),
        .i_load_value  (in_value),
        .o_valid       (dut_valid),
        .i_stall       (out_stall),
        .o_random_word (dut_word)
    );

    gfsr_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (dut_stall),
        .i_req_type    (in_req),
        .i_load_index  (in_index),
        .i_load_value  (in_value),
        .i_out_valid   (dut_valid),
        .i_out_stall   (out_stall),
        .i_random_word (dut_word),
        .o_fail_count  (fail_count),
        .o_waiting     (waiting)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [LOAD_VALUE_BITS-1:0] seed_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // random output stalls, with calm stretches
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (free_left != 0) begin
            free_left--;
            out_stall <= 1'b0;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 9) < 4)
                stall_left = pick_idle();
            else if ($urandom_range(0, 19) == 0)
                free_left = $urandom_range(40, 150);
            else
                free_left = $urandom_range(1, 8);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !dut_stall) || (dut_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL four_tap_gfsr_generator");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic req, input logic [LOAD_INDEX_BITS-1:0] idx,
                             input logic [LOAD_VALUE_BITS-1:0] val);
        int unsigned gap;
        int unsigned r;
        gap = 0;
        if (calm_beats != 0) begin
            calm_beats--;
        end else begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                calm_beats = $urandom_range(30, 120);
            else if (r >= 55)
                gap = pick_idle();
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        in_index <= idx;
        in_value <= val;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
    endtask

    task automatic send_load(input int unsigned idx, input logic [LOAD_VALUE_BITS-1:0] val);
        seeded[idx] = 1'b1;
        stim_pos = 0;
        send_beat(REQ_LOAD, idx[LOAD_INDEX_BITS-1:0], val);
    endtask

    task automatic send_gen();
        int unsigned junk_idx;
        junk_idx = $urandom_range(0, RING - 1);
        stim_pos = (stim_pos + 1) % RING;
        seeded[stim_pos] = 1'b1;
        gen_beats++;
        send_beat(REQ_GEN, junk_idx[LOAD_INDEX_BITS-1:0], $urandom);
    endtask

    // Load every tap slot a run of n_gen beats will read that holds nothing yet,
    // in shuffled order, then run. A cut run is restarted by a stray load.
    task automatic seed_then_generate(input int unsigned n_gen, input bit cut_run);
        int unsigned slot_list [$];
        int unsigned p, s, t, j, k, tmp, cut;
        for (p = 1; p <= n_gen; p++) begin
            for (t = 0; t < NUM_TAPS; t++) begin
                s = (p + RING - TAP_LAGS[t]) % RING;
                if (!(s >= 1 && s < p) && !seeded[s]) begin
                    seeded[s] = 1'b1;
                    slot_list.push_back(s);
                end
            end
        end
        for (j = slot_list.size(); j > 1; j--) begin
            k = $urandom_range(0, j - 1);
            tmp = slot_list[j-1];
            slot_list[j-1] = slot_list[k];
            slot_list[k] = tmp;
        end
        foreach (slot_list[i]) send_load(slot_list[i], seed_word());
        // on a coin toss, end on a tap slot of the first beat so its read follows the write
        if ($urandom_range(0, 1) == 0)
            send_load((1 + RING - TAP_LAGS[$urandom_range(0, NUM_TAPS - 1)]) % RING,
                      seed_word());
        else
            send_load($urandom_range(0, RING - 1), seed_word());
        cut = (cut_run && n_gen > 1) ? $urandom_range(1, n_gen - 1) : n_gen;
        repeat (cut) send_gen();
        if (cut != n_gen) begin
            send_load($urandom_range(0, RING - 1), seed_word());
            repeat (n_gen - cut) send_gen();
        end
    endtask

    initial begin : stimulus
        int unsigned session;
        int unsigned pick;
        int unsigned n_gen;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_load(0, '0);
        send_load(RING - 1, '1);
        seed_then_generate(3, 1'b0);
        send_load(RING - 1, '0);
        send_gen();
        send_gen();

        session = 0;
        gen_beats = 0;
        while (gen_beats < GEN_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90) begin
                repeat ($urandom_range(1, 4)) send_load($urandom_range(0, RING - 1), $urandom);
            end
            if (session == 4 || pick < 3)
                n_gen = $urandom_range(472, 520);
            else if (pick < 13)
                n_gen = $urandom_range(41, 200);
            else
                n_gen = $urandom_range(1, 40);
            seed_then_generate(n_gen, $urandom_range(0, 7) == 0);
            session++;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && waiting == 0)
            $display("PASS four_tap_gfsr_generator");
        else
            $display("FAIL four_tap_gfsr_generator");
        $finish;
    end

endmodule
